/* src/gtbp_pkg.sv */
// Shared types, constants and helpers for the gray threshold bit packer.
package gtbp_pkg;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned CntW   = $clog2(MaxDim);
  localparam int unsigned DimW   = CntW + 1;
  localparam int unsigned CfgDimW = 13;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PixW   = 8;
  localparam int unsigned LumaW  = 24;

  // Q0.16 luma weights, they sum to 65536
  localparam logic [LumaW-1:0] WRed   = LumaW'(19595);
  localparam logic [LumaW-1:0] WGreen = LumaW'(38470);
  localparam logic [LumaW-1:0] WBlue  = LumaW'(7471);

  localparam logic [PixW-1:0] ThresholdReset = PixW'(128);

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgThreshold   = 2'd2,
    CfgColorMode   = 2'd3
  } cfg_idx_e;

  // Classified pixel handed from the luma stage to the packer
  typedef struct packed {
    logic valid;
    logic dark;
  } pix_bit_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DimW-1:0] eff_dim(input logic [CfgDimW-1:0] v);
    logic [DimW-1:0] res;
    if (v == '0) begin
      res = DimW'(1);
    end else if (DimW'(v) > DimW'(MaxDim)) begin
      res = DimW'(MaxDim);
    end else begin
      res = DimW'(v);
    end
    return res;
  endfunction

endpackage

/* src/gtbp_pix_if.sv */
// Pixel channel: valid/ready handshake with one RGB sample set.
interface gtbp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* src/gtbp_byte_if.sv */
// Packed byte channel: valid/ready handshake with one bitmap byte and its flags.
interface gtbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       row_end;
  logic       image_end;

  modport source (output valid, output packed_byte, output row_end, output image_end,
                  input ready);
  modport sink   (input valid, input packed_byte, input row_end, input image_end,
                  output ready);
endinterface

/* src/gray_threshold_bit_packer.sv */
// Top level of the gray threshold bit packer: configuration registers and stage wiring.
//
// Turns a raster-order pixel stream into a 1 bit per pixel bitmap.
// pix_i   : sink, one pixel (red, green, blue) per transaction. In color mode the
//           gray level is (19595*R + 38470*G + 7471*B) >> 16, in gray mode it is R.
//           A pixel whose gray level is below threshold becomes a 1 bit.
// byte_o  : source, one packed byte per transaction, first pixel in bit 7. A byte
//           goes out after every 8 pixels and at each row end (zero padded), with
//           row_end and image_end flags. Zero or one byte per pixel.
// cfg_*   : plain write port; index 0 image_width, 1 image_height, 2 threshold,
//           3 color_mode. Write only while the block is idle.
// Path    : a pixel is registered in the input register on acceptance; the byte it
//           completes is then loaded into the output register and presented on
//           byte_o; a stall on byte_o can hold the pixel in the input register first.
// Rate    : one pixel per cycle sustained while byte_o takes each byte as it is
//           presented; the combinational luma and pack stage sets that figure.
// Stall   : the output register holds a byte until it is taken; pixels that do
//           not finish a byte keep flowing, and one that does waits in the input
//           register, which drops pix_i.ready only when it cannot advance.
// Reset   : positions and the bit accumulator clear; width 1, height 1,
//           threshold 128, color mode on.
module gray_threshold_bit_packer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gtbp_pix_if.sink                      pix_i,
  gtbp_byte_if.source                   byte_o,
  input  logic                          cfg_we_i,
  input  logic [gtbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gtbp_pkg::CfgW-1:0]     cfg_wdata_i
);
  import gtbp_pkg::*;

  // Configuration registers
  logic [CfgDimW-1:0] width_q, height_q;
  logic [PixW-1:0]    threshold_q;
  logic               color_mode_q;

  // Effective dimensions after clamping
  logic [DimW-1:0]    width_eff, height_eff;

  pix_bit_t           pix_bit;
  logic               advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= CfgDimW'(1);
      height_q     <= CfgDimW'(1);
      threshold_q  <= ThresholdReset;
      color_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:  width_q      <= cfg_wdata_i[CfgDimW-1:0];
        CfgImageHeight: height_q     <= cfg_wdata_i[CfgDimW-1:0];
        CfgThreshold:   threshold_q  <= cfg_wdata_i[PixW-1:0];
        CfgColorMode:   color_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign width_eff  = eff_dim(width_q);
  assign height_eff = eff_dim(height_q);

  // Register the pixel and classify it as dark or light
  gtbp_luma u_luma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .color_mode_i (color_mode_q),
    .threshold_i  (threshold_q),
    .advance_i    (advance),
    .bit_o        (pix_bit)
  );

  // Pack bits, track row and image position, hold the outgoing byte
  gtbp_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bit_i     (pix_bit),
    .width_i   (width_eff),
    .height_i  (height_eff),
    .advance_o (advance),
    .byte_o    (byte_o)
  );

endmodule

/* src/gtbp_luma.sv */
// Input register and luma threshold stage of the gray threshold bit packer.
module gtbp_luma (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  gtbp_pix_if.sink                 pix_i,
  input  logic                     color_mode_i,
  input  logic [7:0]               threshold_i,
  input  logic                     advance_i,
  output gtbp_pkg::pix_bit_t       bit_o
);
  import gtbp_pkg::*;

  logic            valid_q, valid_d;
  logic [PixW-1:0] red_q, green_q, blue_q;
  logic            accept;
  logic [LumaW-1:0] luma_sum;
  logic [PixW-1:0]  gray;

  assign pix_i.ready = !valid_q || advance_i;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
    end
  end

  // Constant-coefficient products; the weights sum to 2^16 so the top byte fits
  assign luma_sum = WRed * LumaW'(red_q) + WGreen * LumaW'(green_q) + WBlue * LumaW'(blue_q);
  assign gray     = color_mode_i ? luma_sum[LumaW-1 -: PixW] : red_q;

  assign bit_o.valid = valid_q;
  assign bit_o.dark  = gray < threshold_i;

endmodule

/* src/gtbp_packer.sv */
// Bit packing, row/image position tracking and output register.
module gtbp_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gtbp_pkg::pix_bit_t          bit_i,
  input  logic [gtbp_pkg::DimW-1:0]   width_i,
  input  logic [gtbp_pkg::DimW-1:0]   height_i,
  output logic                        advance_o,
  gtbp_byte_if.source                 byte_o
);
  import gtbp_pkg::*;

  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  logic [7:0]      acc_q, acc_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            out_row_q, out_img_q;

  logic [DimW-1:0] col_next, row_next;
  logic            row_done, img_done, emit, load;
  logic [7:0]      acc_new;

  assign col_next = DimW'(col_q) + DimW'(1);
  assign row_next = DimW'(row_q) + DimW'(1);
  assign row_done = col_next >= width_i;
  assign img_done = row_done && (row_next >= height_i);
  assign emit     = row_done || (col_next[2:0] == 3'd0);
  // MSB first: column 0 of a byte lands in bit 7
  assign acc_new  = acc_q | (bit_i.dark ? (8'h80 >> col_q[2:0]) : 8'h00);

  assign advance_o = bit_i.valid && (!emit || !out_valid_q || byte_o.ready);
  assign load      = advance_o && emit;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && byte_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance_o) begin
      acc_d = emit ? 8'h00 : acc_new;
      if (row_done) begin
        col_d = '0;
        row_d = img_done ? '0 : row_next[CntW-1:0];
      end else begin
        col_d = col_next[CntW-1:0];
      end
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= acc_new;
      out_row_q  <= row_done;
      out_img_q  <= img_done;
    end
  end

  assign byte_o.valid       = out_valid_q;
  assign byte_o.packed_byte = out_byte_q;
  assign byte_o.row_end     = out_row_q;
  assign byte_o.image_end   = out_img_q;

  a_img_implies_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_row_q || !out_img_q))
    else $error("image end flagged on a byte that does not end a row");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (acc_q == 8'h00))
    else $error("accumulator not cleared after a byte was emitted");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && row_done) |=> (col_q == '0))
    else $error("column did not wrap at end of row");

  a_byte_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !row_done) |=> (col_q[2:0] == 3'd0))
    else $error("mid-row byte emitted off a byte boundary");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !byte_o.ready) |-> !load)
    else $error("pending output byte overwritten while stalled");

endmodule
